// ----- hw/rtl/ulav_pkg.sv -----
// shared types, constants and helpers of the ula video beam generator
package ulav_pkg;

    localparam int DISPLAY_SIZE = 6912;
    localparam int BITMAP_DEPTH = 6144;
    localparam int ATTR_DEPTH   = DISPLAY_SIZE - BITMAP_DEPTH;
    localparam int PAPER_LINES  = 192;
    localparam int PAPER_DOTS   = 256;
    localparam int FRAMES_WRAP  = 15;

    // configuration register indexes
    localparam logic [2:0] REG_DOTS_PER_LINE     = 3'd0;
    localparam logic [2:0] REG_LINES_PER_FRAME   = 3'd1;
    localparam logic [2:0] REG_PAPER_FIRST_LINE  = 3'd2;
    localparam logic [2:0] REG_INTERRUPT_LENGTH  = 3'd3;
    localparam logic [2:0] REG_PAPER_FIRST_DOT   = 3'd4;
    localparam logic [2:0] REG_VISIBLE_DOT_COUNT = 3'd5;
    localparam logic [2:0] REG_START_DOT         = 3'd6;

    localparam logic [7:0] LEVEL_NORMAL = 8'hCD;
    localparam logic [7:0] LEVEL_BRIGHT = 8'hFF;
    localparam logic [7:0] BUS_IDLE     = 8'hFF;

    typedef struct packed {
        logic [9:0] dots_per_line;
        logic [8:0] frame_lines;
        logic [8:0] paper_first_line;
        logic [7:0] interrupt_length;
        logic [9:0] paper_first_dot;
        logic [9:0] visible_dot_count;
        logic [9:0] start_dot;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dots_per_line:     10'd448,
        frame_lines:       9'd312,
        paper_first_line:  9'd64,
        interrupt_length:  8'd64,
        paper_first_dot:   10'd48,
        visible_dot_count: 10'd352,
        start_dot:         10'd0
    };

    // product of the reset wrap points
    localparam logic [18:0] FRAME_DOTS_RESET = 19'd139776;

    // one dot in flight between the beam counters and the renderer
    typedef struct packed {
        logic       is_write;
        logic       paper;
        logic       visible;
        logic       fetch;
        logic [3:0] px_lo;
        logic [2:0] border;
        logic       flash;
        logic       irq;
        logic [8:0] line;
        logic [9:0] dot;
    } beat_t;

    // display store access for one accepted item
    typedef struct packed {
        logic        rd_en;
        logic [12:0] bm_addr0;
        logic [12:0] bm_addr1;
        logic [9:0]  at_addr0;
        logic [9:0]  at_addr1;
        logic        bm_we;
        logic        at_we;
        logic [12:0] wr_bm_addr;
        logic [9:0]  wr_at_addr;
        logic [7:0]  wr_data;
    } mem_req_t;

    function automatic logic [7:0] level_of(input logic on, input logic bright);
        logic [7:0] lvl;
        lvl = 8'd0;
        if (on)
        begin
            lvl = bright ? LEVEL_BRIGHT : LEVEL_NORMAL;
        end
        return lvl;
    endfunction

endpackage

// ----- hw/rtl/ulav_if.sv -----
// valid/ready channel interfaces of the ula video beam generator
interface ulav_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [12:0] write_address;
    logic [7:0]  write_data;
    logic [2:0]  border_colour;

    modport source (output valid, mode, write_address, write_data, border_colour,
                    input ready);
    modport sink (input valid, mode, write_address, write_data, border_colour,
                  output ready);
endinterface

interface ulav_out_if;
    logic       valid;
    logic       ready;
    logic       pixel_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] beam_line;
    logic [9:0] beam_dot;
    logic       interrupt_active;
    logic [7:0] idle_bus_byte;
    logic       fetch_happened;

    modport source (output valid, pixel_valid, red, green, blue, beam_line, beam_dot,
                    interrupt_active, idle_bus_byte, fetch_happened,
                    input ready);
    modport sink (input valid, pixel_valid, red, green, blue, beam_line, beam_dot,
                  interrupt_active, idle_bus_byte, fetch_happened,
                  output ready);
endinterface

interface ulav_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ulav_store.sv -----
// display store: bitmap and attribute memories, two registered reads each
module ulav_store (
    input  logic              clk,
    input  ulav_pkg::mem_req_t req,
    output logic [3:0][7:0]   fetch_bytes
);
    import ulav_pkg::*;

    logic [7:0] bitmap_mem [BITMAP_DEPTH];
    logic [7:0] attr_mem   [ATTR_DEPTH];

    logic [7:0] bm0_reg;
    logic [7:0] bm1_reg;
    logic [7:0] at0_reg;
    logic [7:0] at1_reg;

    always_ff @(posedge clk)
    begin
        if (req.bm_we)
        begin
            bitmap_mem[req.wr_bm_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            bm0_reg <= bitmap_mem[req.bm_addr0];
            bm1_reg <= bitmap_mem[req.bm_addr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.at_we)
        begin
            attr_mem[req.wr_at_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            at0_reg <= attr_mem[req.at_addr0];
            at1_reg <= attr_mem[req.at_addr1];
        end
    end

    // order: bitmap0, attr0, bitmap1, attr1
    assign fetch_bytes = {at1_reg, bm1_reg, at0_reg, bm0_reg};

endmodule

// ----- hw/rtl/ulav_beam.sv -----
// beam counters, configuration registers and display store addressing
module ulav_beam (
    input  logic               clk,
    input  logic               rst_n,
    ulav_cfg_if.sink           cfg,
    ulav_in_if.sink            tick,
    input  logic               take,
    output logic               beat_valid,
    output ulav_pkg::beat_t    beat,
    output ulav_pkg::mem_req_t req
);
    import ulav_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic [18:0] frame_dots_reg;
    logic [9:0]  dot_reg, dot_next;
    logic [8:0]  line_reg, line_next;
    logic [18:0] frame_reg, frame_next;
    logic [3:0]  frames_reg, frames_next;
    logic        flash_reg, flash_next;
    logic [2:0]  border_reg, border_next;
    logic        beat_valid_reg, beat_valid_next;
    beat_t       beat_reg, beat_next;

    logic        accept;
    logic        is_tick;
    logic [9:0]  line_top;
    logic [10:0] dot_top;
    logic        paper;
    logic [7:0]  px;
    logic [7:0]  y;
    logic        fetch;
    logic [10:0] dot_inc;
    logic [9:0]  line_inc;
    logic [19:0] frame_inc;

    assign cfg.ready  = 1'b1;
    assign tick.ready = !beat_valid_reg || take;
    assign accept     = tick.valid && tick.ready;
    assign is_tick    = accept && !tick.mode;

    // paper window and position inside it
    always_comb
    begin
        line_top = {1'b0, cfg_reg.paper_first_line} + 10'(PAPER_LINES);
        dot_top  = {1'b0, cfg_reg.paper_first_dot} + 11'(PAPER_DOTS);
        paper    = (line_reg >= cfg_reg.paper_first_line) && ({1'b0, line_reg} < line_top)
                && (dot_reg >= cfg_reg.paper_first_dot) && ({1'b0, dot_reg} < dot_top);
        px       = 8'(dot_reg - cfg_reg.paper_first_dot);
        y        = 8'(line_reg - {1'b0, cfg_reg.paper_first_line});
        fetch    = paper && (px[3:0] == 4'd0);
    end

    // scrambled bitmap rows, linear attribute cells
    always_comb
    begin
        req.rd_en      = is_tick && fetch;
        req.bm_addr0   = {y[7:6], y[2:0], y[5:3], px[7:4], 1'b0};
        req.bm_addr1   = {y[7:6], y[2:0], y[5:3], px[7:4], 1'b1};
        req.at_addr0   = {y[7:3], px[7:4], 1'b0};
        req.at_addr1   = {y[7:3], px[7:4], 1'b1};
        req.bm_we      = accept && tick.mode && (tick.write_address < 13'(BITMAP_DEPTH));
        req.at_we      = accept && tick.mode && (tick.write_address >= 13'(BITMAP_DEPTH))
                      && (tick.write_address < 13'(DISPLAY_SIZE));
        req.wr_bm_addr = tick.write_address;
        req.wr_at_addr = tick.write_address[9:0];
        req.wr_data    = tick.write_data;
    end

    always_comb
    begin
        border_next = border_reg;
        if (is_tick && (dot_reg[2:0] == 3'd0))
        begin
            border_next = tick.border_colour;
        end

        beat_next          = '0;
        beat_next.is_write = tick.mode;
        if (!tick.mode)
        begin
            beat_next.paper   = paper;
            beat_next.visible = dot_reg < cfg_reg.visible_dot_count;
            beat_next.fetch   = fetch;
            beat_next.px_lo   = px[3:0];
            beat_next.border  = border_next;
            beat_next.flash   = flash_reg;
            beat_next.irq     = frame_reg < 19'(cfg_reg.interrupt_length);
            beat_next.line    = line_reg;
            beat_next.dot     = dot_reg;
        end

        beat_valid_next = beat_valid_reg;
        if (accept)
        begin
            beat_valid_next = 1'b1;
        end
        else if (take)
        begin
            beat_valid_next = 1'b0;
        end
    end

    // counter advance, start dot write reloads the dot position
    always_comb
    begin
        dot_inc     = {1'b0, dot_reg} + 11'd1;
        line_inc    = {1'b0, line_reg} + 10'd1;
        frame_inc   = {1'b0, frame_reg} + 20'd1;
        dot_next    = dot_reg;
        line_next   = line_reg;
        frame_next  = frame_reg;
        frames_next = frames_reg;
        flash_next  = flash_reg;
        if (is_tick)
        begin
            if (dot_inc >= {1'b0, cfg_reg.dots_per_line})
            begin
                dot_next = 10'd0;
                if (line_inc >= {1'b0, cfg_reg.frame_lines})
                begin
                    line_next = 9'd0;
                end
                else
                begin
                    line_next = line_inc[8:0];
                end
            end
            else
            begin
                dot_next = dot_inc[9:0];
            end

            if (frame_inc >= {1'b0, frame_dots_reg})
            begin
                frame_next  = 19'd0;
                frames_next = frames_reg + 4'd1;
                if (frames_reg == 4'(FRAMES_WRAP))
                begin
                    flash_next = !flash_reg;
                end
            end
            else
            begin
                frame_next = frame_inc[18:0];
            end
        end

        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_DOTS_PER_LINE:     cfg_next.dots_per_line     = cfg.data;
                REG_LINES_PER_FRAME:   cfg_next.frame_lines       = cfg.data[8:0];
                REG_PAPER_FIRST_LINE:  cfg_next.paper_first_line  = cfg.data[8:0];
                REG_INTERRUPT_LENGTH:  cfg_next.interrupt_length  = cfg.data[7:0];
                REG_PAPER_FIRST_DOT:   cfg_next.paper_first_dot   = cfg.data;
                REG_VISIBLE_DOT_COUNT: cfg_next.visible_dot_count = cfg.data;
                REG_START_DOT:
                begin
                    cfg_next.start_dot = cfg.data;
                    dot_next           = cfg.data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= CFG_RESET;
            frame_dots_reg <= FRAME_DOTS_RESET;
            dot_reg        <= CFG_RESET.start_dot;
            line_reg       <= '0;
            frame_reg      <= '0;
            frames_reg     <= '0;
            flash_reg      <= 1'b0;
            border_reg     <= '0;
            beat_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            frame_dots_reg <= 19'({9'd0, cfg_next.dots_per_line}
                                  * {10'd0, cfg_next.frame_lines});
            dot_reg        <= dot_next;
            line_reg       <= line_next;
            frame_reg      <= frame_next;
            frames_reg     <= frames_next;
            flash_reg      <= flash_next;
            border_reg     <= border_next;
            beat_valid_reg <= beat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_valid = beat_valid_reg;
    assign beat       = beat_reg;

endmodule

// ----- hw/rtl/ulav_render.sv -----
// pixel colour, idle bus byte and the output register
module ulav_render (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            beat_valid,
    input  ulav_pkg::beat_t beat,
    input  logic [3:0][7:0] fetch_bytes,
    output logic            take,
    ulav_out_if.source      pixel
);
    import ulav_pkg::*;

    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] beam_line;
        logic [9:0] beam_dot;
        logic       interrupt_active;
        logic [7:0] idle_bus_byte;
        logic       fetch_happened;
    } result_t;

    logic [3:0][7:0] group_reg;
    logic [3:0][7:0] bytes;
    logic            out_valid_reg;
    result_t         result_reg, result_next;

    logic [7:0] bits;
    logic [7:0] attr;
    logic [2:0] ink;
    logic [2:0] pap;
    logic [2:0] colour;
    logic       bright;

    assign take  = !out_valid_reg || pixel.ready;
    // a fetching dot uses the fresh store data, later dots the held group
    assign bytes = beat.fetch ? fetch_bytes : group_reg;

    always_comb
    begin
        bits   = beat.px_lo[3] ? bytes[2] : bytes[0];
        attr   = beat.px_lo[3] ? bytes[3] : bytes[1];
        ink    = attr[2:0];
        pap    = attr[5:3];
        bright = 1'b0;
        colour = beat.border;
        if (beat.paper)
        begin
            bright = attr[6];
            if (attr[7] && beat.flash)
            begin
                ink = attr[5:3];
                pap = attr[2:0];
            end
            colour = bits[3'd7 - beat.px_lo[2:0]] ? ink : pap;
        end

        result_next = '0;
        if (!beat.is_write)
        begin
            if (beat.visible)
            begin
                result_next.pixel_valid = 1'b1;
                result_next.red         = level_of(colour[1], bright);
                result_next.green       = level_of(colour[2], bright);
                result_next.blue        = level_of(colour[0], bright);
            end
            result_next.beam_line        = beat.line;
            result_next.beam_dot         = beat.dot;
            result_next.interrupt_active = beat.irq;
            result_next.fetch_happened   = beat.fetch;
            result_next.idle_bus_byte    = BUS_IDLE;
            if (beat.paper && !beat.px_lo[3])
            begin
                result_next.idle_bus_byte = bytes[beat.px_lo[2:1]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            group_reg     <= '0;
        end
        else if (take)
        begin
            out_valid_reg <= beat_valid;
            if (beat_valid && !beat.is_write && beat.fetch)
            begin
                group_reg <= fetch_bytes;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign pixel.valid            = out_valid_reg;
    assign pixel.pixel_valid      = result_reg.pixel_valid;
    assign pixel.red              = result_reg.red;
    assign pixel.green            = result_reg.green;
    assign pixel.blue             = result_reg.blue;
    assign pixel.beam_line        = result_reg.beam_line;
    assign pixel.beam_dot         = result_reg.beam_dot;
    assign pixel.interrupt_active = result_reg.interrupt_active;
    assign pixel.idle_bus_byte    = result_reg.idle_bus_byte;
    assign pixel.fetch_happened   = result_reg.fetch_happened;

endmodule

// ----- hw/rtl/ula_video_beam_generator.sv -----
// top level of the ula video beam generator
// path: an item's beat is registered at its accept edge, its result when the renderer takes the beat
// throughput: one item per cycle while the output is not stalled, ready passes straight back from the output;
//   a fetching dot reads all four group bytes in parallel at its accept edge
// reset: counters, configuration, border latch, group bytes and valid flags go to reset values;
//   the display store is not cleared and reads undefined until written
module ula_video_beam_generator (
    input  logic       clk,
    input  logic       rst_n,
    ulav_in_if.sink    tick,
    ulav_out_if.source pixel,
    ulav_cfg_if.sink   cfg
);
    import ulav_pkg::*;

    // beat stage handshake: the renderer takes a beat whenever its output
    // register is empty or being emptied
    logic            take;
    logic            beat_valid;
    beat_t           beat;

    // store access issued at the accept edge, read data registered there alongside the beat
    mem_req_t        req;
    logic [3:0][7:0] fetch_bytes;

    // counters and addressing; writes to the store also pass through here
    // and travel down the pipe as an all-zero result
    ulav_beam u_beam (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tick       (tick),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat),
        .req        (req)
    );

    // bitmap and attribute memories; read data stays put while the beat
    // stage is stalled, since reads happen only on an accepted item
    ulav_store u_store (
        .clk         (clk),
        .req         (req),
        .fetch_bytes (fetch_bytes)
    );

    // colour lookup, flash swap, idle bus byte and the output register
    ulav_render u_render (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_valid  (beat_valid),
        .beat        (beat),
        .fetch_bytes (fetch_bytes),
        .take        (take),
        .pixel       (pixel)
    );

endmodule

// ----- hw/rtl/ulav_checker.sv -----
// port level checks of the ula video beam generator and their binding
module ulav_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       pixel_valid,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [9:0] beam_dot
);
    import ulav_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(beam_dot) && $stable(red))
        else $error("stalled item changed");

    // a new result appears only after its item was taken and passed the beat register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("item appeared without an accepted input");

    // retrace and write results are black
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pixel_valid |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
        else $error("colour outside visible dot");

    // levels are off, normal or bright
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_valid |->
            (red == 8'd0 || red == LEVEL_NORMAL || red == LEVEL_BRIGHT)
            && (green == 8'd0 || green == LEVEL_NORMAL || green == LEVEL_BRIGHT)
            && (blue == 8'd0 || blue == LEVEL_NORMAL || blue == LEVEL_BRIGHT))
        else $error("illegal colour level");

endmodule

bind ula_video_beam_generator ulav_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (tick.valid),
    .in_ready    (tick.ready),
    .out_valid   (pixel.valid),
    .out_ready   (pixel.ready),
    .pixel_valid (pixel.pixel_valid),
    .red         (pixel.red),
    .green       (pixel.green),
    .blue        (pixel.blue),
    .beam_dot    (pixel.beam_dot)
);
